### rtl/core/aes_pkg.sv
package aes_pkg;

    typedef logic [7:0]   t_byte;
    typedef logic [127:0] t_block;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned IDX_W   = 1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    localparam t_byte GF_POLY  = 8'h1b;
    localparam t_byte RCON_ONE = 8'h01;

    // payload of one round stage: state, the round key it came with and its round constant
    typedef struct packed {
        t_block st;
        t_block key;
        t_byte  rcon;
    } t_stage;

    function automatic t_byte sbox(input t_byte v);
        t_byte r;
        unique case (v)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_byte gf_double(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // byte i of a block, byte 0 in the top bits
    function automatic t_byte get_byte(input t_block b, input int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

endpackage

### rtl/core/aes_stream_if.sv
interface aes_stream_if;
    logic                   valid;
    logic                   ready;
    logic [aes_pkg::HALF_W-1:0] data_high;
    logic [aes_pkg::HALF_W-1:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

### rtl/core/aes_round_cell.sv
// One cipher round plus the next round-key step, registered at its output.
module aes_round_cell #(
    parameter bit LAST = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  aes_pkg::t_stage  i_stage,
    output logic             o_vld,
    output aes_pkg::t_stage  o_stage
);
    aes_pkg::t_block w_key;
    aes_pkg::t_block w_sr;
    aes_pkg::t_block w_mix;
    aes_pkg::t_byte  w_t [4];
    aes_pkg::t_stage n_stage;
    aes_pkg::t_stage r_stage;
    logic            r_vld;

    // key expansion step
    always_comb begin
        w_t[0] = aes_pkg::sbox(aes_pkg::get_byte(i_stage.key, 13)) ^ i_stage.rcon;
        w_t[1] = aes_pkg::sbox(aes_pkg::get_byte(i_stage.key, 14));
        w_t[2] = aes_pkg::sbox(aes_pkg::get_byte(i_stage.key, 15));
        w_t[3] = aes_pkg::sbox(aes_pkg::get_byte(i_stage.key, 12));
        for (int i = 0; i < 4; i++) begin
            w_key[aes_pkg::BLOCK_W-1-8*i -: 8] = aes_pkg::get_byte(i_stage.key, i) ^ w_t[i];
        end
        for (int i = 4; i < 16; i++) begin
            w_key[aes_pkg::BLOCK_W-1-8*i -: 8] =
                aes_pkg::get_byte(i_stage.key, i) ^ w_key[aes_pkg::BLOCK_W-1-8*(i-4) -: 8];
        end
    end

    // SubBytes, ShiftRows, MixColumns (not in the last round), AddRoundKey
    always_comb begin
        aes_pkg::t_byte a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                w_sr[aes_pkg::BLOCK_W-1-8*(c*4+r) -: 8] =
                    aes_pkg::sbox(aes_pkg::get_byte(i_stage.st, ((c + r) % 4) * 4 + r));
            end
        end
        w_mix = w_sr;
        for (int c = 0; c < 4; c++) begin
            a0  = aes_pkg::get_byte(w_sr, c*4);
            a1  = aes_pkg::get_byte(w_sr, c*4+1);
            a2  = aes_pkg::get_byte(w_sr, c*4+2);
            a3  = aes_pkg::get_byte(w_sr, c*4+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            w_mix[aes_pkg::BLOCK_W-1-8*(c*4)   -: 8] = a0 ^ all ^ aes_pkg::gf_double(a0 ^ a1);
            w_mix[aes_pkg::BLOCK_W-1-8*(c*4+1) -: 8] = a1 ^ all ^ aes_pkg::gf_double(a1 ^ a2);
            w_mix[aes_pkg::BLOCK_W-1-8*(c*4+2) -: 8] = a2 ^ all ^ aes_pkg::gf_double(a2 ^ a3);
            w_mix[aes_pkg::BLOCK_W-1-8*(c*4+3) -: 8] = a3 ^ all ^ aes_pkg::gf_double(a3 ^ a0);
        end
        n_stage.st   = (LAST ? w_sr : w_mix) ^ w_key;
        n_stage.key  = w_key;
        n_stage.rcon = aes_pkg::gf_double(i_stage.rcon);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;
endmodule

### rtl/core/aes128_block_encrypt_core.sv
// AES-128 encryption, a chain of ten round cells behind an input key-add stage.
// A request is registered in the key-add stage and then in each round cell in turn.
// Throughput: one block per cycle; the chain stalls as a whole only while the
// result at the end is not taken.
// Reset (synchronous, active low) clears all stage valids and sets the key to zero.
module aes128_block_encrypt_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    aes_stream_if.sink                 s_in,
    aes_stream_if.source               m_out,
    input  logic                       i_cfg_we,
    input  logic [aes_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [aes_pkg::HALF_W-1:0] i_cfg_data
);
    localparam int NCELL = 10;

    logic [aes_pkg::HALF_W-1:0] r_key_high;
    logic [aes_pkg::HALF_W-1:0] r_key_low;
    logic                       r_vld0;
    aes_pkg::t_stage            r_stage0;
    logic                       w_adv;
    logic            w_vld [NCELL+1];
    aes_pkg::t_stage w_stage [NCELL+1];

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aes_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                aes_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole chain moves unless the result at the end is stalled
    assign w_adv       = !w_vld[NCELL] || m_out.ready;
    assign s_in.ready  = w_adv;

    // initial AddRoundKey stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (w_adv) begin
            r_vld0 <= s_in.valid;
        end
        if (w_adv) begin
            r_stage0.st   <= {s_in.data_high, s_in.data_low} ^ {r_key_high, r_key_low};
            r_stage0.key  <= {r_key_high, r_key_low};
            r_stage0.rcon <= aes_pkg::RCON_ONE;
        end
    end

    assign w_vld[0]   = r_vld0;
    assign w_stage[0] = r_stage0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        aes_round_cell #(.LAST(g == NCELL-1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_vld[g]),
            .i_stage (w_stage[g]),
            .o_vld   (w_vld[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    assign m_out.valid     = w_vld[NCELL];
    assign m_out.data_high = w_stage[NCELL].st[aes_pkg::BLOCK_W-1 -: aes_pkg::HALF_W];
    assign m_out.data_low  = w_stage[NCELL].st[aes_pkg::HALF_W-1:0];
endmodule

### rtl/core/aes_core_checker.sv
module aes_core_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_high,
    input logic [63:0] out_low
);
    // stalled result holds its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
        else $error("result changed while stalled");

    // input side is open whenever output side is free
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ready |-> in_ready)
        else $error("input blocked with free output");

    // input blocked only by a stalled result
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without stall");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");
endmodule

bind aes128_block_encrypt_core aes_core_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (s_in.ready),
    .out_valid (m_out.valid),
    .out_ready (m_out.ready),
    .out_high  (m_out.data_high),
    .out_low   (m_out.data_low)
);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [aes_pkg::IDX_W-1:0] i_cfg_idx;
    logic [aes_pkg::HALF_W-1:0] i_cfg_data;

    aes_stream_if s_in ();
    aes_stream_if m_out ();

    aes128_block_encrypt_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (s_in.sink),
        .m_out     (m_out.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    localparam int LATENCY     = 10;
    localparam int STALL_LIMIT = 5000;

    // model copy of the key registers
    logic [aes_pkg::HALF_W-1:0] key_hi_q;
    logic [aes_pkg::HALF_W-1:0] key_lo_q;
    logic [127:0] cipher_q[$];
    int  errors;
    bit  quiet_send;
    bit  quiet_recv;
    bit  hold_recv;
    int  idle_cnt;

    // substitution table for the predictor
    logic [7:0] sub_tbl[256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 encryption of one block under the current key copy
    function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
        logic [7:0] s[16];
        logic [7:0] k[16];
        logic [7:0] t[16];
        logic [7:0] w[4];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] key, res;
        key = {key_hi_q, key_lo_q};
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            s[i] = pt[127-8*i -: 8] ^ key[127-8*i -: 8];
            k[i] = key[127-8*i -: 8];
        end
        for (int rnd = 0; rnd < 10; rnd++) begin
            w[0] = sub_tbl[k[13]] ^ rc;
            w[1] = sub_tbl[k[14]];
            w[2] = sub_tbl[k[15]];
            w[3] = sub_tbl[k[12]];
            for (int i = 0; i < 4; i++) k[i] ^= w[i];
            for (int i = 4; i < 16; i++) k[i] ^= k[i-4];
            rc = xtime(rc);
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[c*4+r] = sub_tbl[s[((c+r)%4)*4+r]];
            if (rnd != 9) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
                    t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
                    t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
                    t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predict at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && s_in.valid && s_in.ready)
            cipher_q.push_back(aes_encrypt({s_in.data_high, s_in.data_low}));
    end

    // result checker
    always @(posedge i_clk) begin
        logic [127:0] exp_ct;
        if (i_rst_n && m_out.valid && m_out.ready) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected result %h_%h", $time, m_out.data_high,
                         m_out.data_low);
                errors++;
            end else begin
                exp_ct = cipher_q.pop_front();
                if (m_out.data_high !== exp_ct[127:64]) begin
                    $display("%0t: cipher_high expected %h actual %h", $time,
                             exp_ct[127:64], m_out.data_high);
                    errors++;
                end
                if (m_out.data_low !== exp_ct[63:0]) begin
                    $display("%0t: cipher_low expected %h actual %h", $time,
                             exp_ct[63:0], m_out.data_low);
                    errors++;
                end
            end
        end
    end

    // receiver ready
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_recv)
            m_out.ready <= 1'b0;
        else if (quiet_recv)
            m_out.ready <= 1'b1;
        else
            m_out.ready <= ($urandom_range(99) >= 30);
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if ((s_in.valid && s_in.ready) || (m_out.valid && m_out.ready) || !i_rst_n)
            idle_cnt <= 0;
        else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // one request; valid stays high so another can follow directly,
    // drain drops it at the end of a burst
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        if (!quiet_send)
            while ($urandom_range(99) < 30) begin
                s_in.valid <= 1'b0;
                @(negedge i_clk);
            end
        s_in.valid     <= 1'b1;
        s_in.data_high <= hi;
        s_in.data_low  <= lo;
        do @(posedge i_clk); while (!s_in.ready);
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_in.valid <= 1'b0;
        while (cipher_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_key(input logic [aes_pkg::IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == aes_pkg::REG_KEY_HIGH) key_hi_q = val;
        else key_lo_q = val;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // zero key after reset, field extremes
    task automatic test_directed;
        send_block('0, '0);
        send_block('1, '1);
        send_block('1, '0);
        send_block('0, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();
        // standard vector key, extremes of key
        write_key(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
        write_key(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        drain();
        write_key(aes_pkg::REG_KEY_HIGH, '1);
        write_key(aes_pkg::REG_KEY_LOW, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h8000000000000000, 64'h0000000000000001);
        drain();
    endtask

    // random blocks under several random keys
    task automatic test_random;
        for (int ph = 0; ph < 6; ph++) begin
            write_key(aes_pkg::REG_KEY_HIGH, rand64());
            write_key(aes_pkg::REG_KEY_LOW, rand64());
            quiet_send = (ph == 2);
            quiet_recv = (ph == 2);
            for (int n = 0; n < 60; n++) send_block(rand64(), rand64());
            drain();
        end
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
    endtask

    // receiver held off while the sender keeps pushing
    task automatic test_backpressure;
        write_key(aes_pkg::REG_KEY_HIGH, rand64());
        write_key(aes_pkg::REG_KEY_LOW, rand64());
        fork
            begin
                hold_recv = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_recv = 1'b0;
            end
            begin
                quiet_send = 1'b1;
                for (int n = 0; n < 40; n++) send_block(rand64(), rand64());
                quiet_send = 1'b0;
                drain();
            end
        join
    endtask

    initial begin
        errors      = 0;
        quiet_send  = 1'b0;
        quiet_recv  = 1'b0;
        hold_recv   = 1'b0;
        key_hi_q    = '0;
        key_lo_q    = '0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = aes_pkg::REG_KEY_HIGH;
        i_cfg_data  = '0;
        s_in.valid  = 1'b0;
        s_in.data_high = '0;
        s_in.data_low  = '0;
        m_out.ready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        if (errors == 0 && cipher_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### sim.f
rtl/core/aes_pkg.sv
rtl/core/aes_stream_if.sv
rtl/core/aes_round_cell.sv
rtl/core/aes128_block_encrypt_core.sv
rtl/core/aes_core_checker.sv
verif/tb_top.sv
